### design/rsi_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rsi_pkg
// Shared types and constants of the ray / sphere intersection pipeline.
// ============================================================================
package rsi_pkg;

    // Fraction bits of coordinates and of directions.
    localparam int FRAC_BITS = 16;
    localparam int DIR_FRAC  = 14;

    // Reset radius is 1.0 in Q16.16.
    localparam logic [30:0] RADIUS_RESET = 31'(1) << FRAC_BITS;

    // Rounding offset for products with a Q2.14 direction.
    localparam int DIR_HALF = 1 << (DIR_FRAC - 1);

    // Iterations of the square root and of the normal divider.
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 15;

    // Stages from request to result strobe.
    localparam int RSI_LAT = 14 + SQRT_STEPS + DIV_STEPS;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } hit_t;

endpackage

### design/ray_sphere_intersect.sv
`timescale 1ns / 1ps
// ============================================================================
// ray_sphere_intersect
// Pipelined hit test of one ray against one configured sphere.
// ============================================================================
// A request (one ray) is taken on every cycle in which start is high; busy is
// always low. Its result appears on result with done high for exactly one
// cycle, in request order, and the receiver cannot hold it off. The pipeline
// is made of the 31 stages of the integer square root of the discriminant,
// the 15 stages of the three parallel normal dividers and fourteen stages
// of multiplies, sums and rounding. The sphere is read straight from the
// configuration registers in the stages that use it, so they must only be
// written while no request is in flight.
module ray_sphere_intersect
    import rsi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  ray_t        ray,
    output logic        done,
    output hit_t        result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic signed [31:0] center_reg [3];
    logic [30:0]        radius_reg;
    logic [30:0]        r_eff;
    reg_idx_t           reg_sel;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign reg_sel = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            radius_reg    <= RADIUS_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_CENTER_X: center_reg[0] <= pwdata;
                REG_CENTER_Y: center_reg[1] <= pwdata;
                REG_CENTER_Z: center_reg[2] <= pwdata;
                REG_RADIUS:   radius_reg    <= pwdata[30:0];
                default:      radius_reg    <= radius_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_CENTER_X: prdata = center_reg[0];
            REG_CENTER_Y: prdata = center_reg[1];
            REG_CENTER_Z: prdata = center_reg[2];
            REG_RADIUS:   prdata = {1'b0, radius_reg};
            default:      prdata = '0;
        endcase
    end

    // A zero radius is treated as one LSB so the divider never sees zero.
    assign r_eff = (radius_reg == '0) ? 31'd1 : radius_reg;

    // ------------------------------------------------------------------------
    // Valid bits travel down a shift line beside the data. Nothing stalls,
    // so the data registers simply load every cycle.
    // ------------------------------------------------------------------------
    logic [RSI_LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[RSI_LAT-2:0], start && !busy};
        end
    end

    assign done = vld_reg[RSI_LAT-1];

    // ------------------------------------------------------------------------
    // Stage 1: take the ray, form D = start - center.
    // ------------------------------------------------------------------------
    logic signed [31:0] s1_reg [3];
    logic signed [15:0] dv1_reg [3];
    logic signed [32:0] dif1_reg [3];
    logic signed [31:0] s_in [3];
    logic signed [15:0] dv_in [3];

    assign s_in[0]  = ray.start_x;
    assign s_in[1]  = ray.start_y;
    assign s_in[2]  = ray.start_z;
    assign dv_in[0] = ray.dir_x;
    assign dv_in[1] = ray.dir_y;
    assign dv_in[2] = ray.dir_z;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_reg[i]   <= s_in[i];
            dv1_reg[i]  <= dv_in[i];
            dif1_reg[i] <= 33'(s_in[i]) - 33'(center_reg[i]);
        end
    end

    // Stage 2: products dir * D for the dot product.
    logic signed [31:0] s2_reg [3];
    logic signed [15:0] dv2_reg [3];
    logic signed [32:0] dif2_reg [3];
    logic signed [48:0] prod2_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_reg[i]    <= s1_reg[i];
            dv2_reg[i]   <= dv1_reg[i];
            dif2_reg[i]  <= dif1_reg[i];
            prod2_reg[i] <= 49'(dif1_reg[i]) * 49'(dv1_reg[i]);
        end
    end

    // Stage 3: sum of the products, rounded back to Q16.16 to give b.
    logic signed [31:0] s3_reg [3];
    logic signed [15:0] dv3_reg [3];
    logic signed [32:0] dif3_reg [3];
    logic signed [36:0] bq3_reg;
    logic signed [50:0] b2_sum;
    logic signed [50:0] b2_shift;

    assign b2_sum   = 51'(prod2_reg[0]) + 51'(prod2_reg[1]) + 51'(prod2_reg[2])
                    + 51'(DIR_HALF);
    assign b2_shift = b2_sum >>> DIR_FRAC;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s3_reg[i]   <= s2_reg[i];
            dv3_reg[i]  <= dv2_reg[i];
            dif3_reg[i] <= dif2_reg[i];
        end
        bq3_reg <= b2_shift[36:0];
    end

    // Stage 4: b * dir, the foot of the perpendicular from the centre.
    logic signed [31:0] s4_reg [3];
    logic signed [15:0] dv4_reg [3];
    logic signed [32:0] dif4_reg [3];
    logic signed [36:0] bq4_reg;
    logic signed [52:0] m4_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s4_reg[i]   <= s3_reg[i];
            dv4_reg[i]  <= dv3_reg[i];
            dif4_reg[i] <= dif3_reg[i];
            m4_reg[i]   <= 53'(bq3_reg) * 53'(dv3_reg[i]);
        end
        bq4_reg <= bq3_reg;
    end

    // Stage 5: perpendicular component and its magnitude. A component longer
    // than the radius already rules out a hit.
    logic signed [31:0] s5_reg [3];
    logic signed [15:0] dv5_reg [3];
    logic signed [36:0] bq5_reg;
    logic [30:0]        mag5_reg [3];
    logic               miss5_reg;
    logic signed [52:0] m_rnd [3];
    logic signed [52:0] m_shift [3];
    logic signed [39:0] perp [3];
    logic [39:0]        perp_mag [3];
    logic [2:0]         perp_over;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m_rnd[i]     = m4_reg[i] + 53'(DIR_HALF);
            m_shift[i]   = m_rnd[i] >>> DIR_FRAC;
            perp[i]      = 40'(dif4_reg[i]) - m_shift[i][39:0];
            perp_mag[i]  = perp[i][39] ? 40'(-perp[i]) : 40'(perp[i]);
            perp_over[i] = perp_mag[i] > {9'b0, r_eff};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s5_reg[i]   <= s4_reg[i];
            dv5_reg[i]  <= dv4_reg[i];
            mag5_reg[i] <= perp_mag[i][30:0];
        end
        bq5_reg   <= bq4_reg;
        miss5_reg <= |perp_over;
    end

    // Stage 6: squares of the perpendicular components and of the radius.
    logic signed [31:0] s6_reg [3];
    logic signed [15:0] dv6_reg [3];
    logic signed [36:0] bq6_reg;
    logic [61:0]        sq6_reg [3];
    logic [61:0]        r2_6_reg;
    logic               miss6_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s6_reg[i]  <= s5_reg[i];
            dv6_reg[i] <= dv5_reg[i];
            sq6_reg[i] <= 62'(mag5_reg[i]) * 62'(mag5_reg[i]);
        end
        bq6_reg   <= bq5_reg;
        r2_6_reg  <= 62'(r_eff) * 62'(r_eff);
        miss6_reg <= miss5_reg;
    end

    // Stage 7: squared distance of the ray from the centre.
    logic signed [31:0] s7_reg [3];
    logic signed [15:0] dv7_reg [3];
    logic signed [36:0] bq7_reg;
    logic [63:0]        sum7_reg;
    logic [61:0]        r2_7_reg;
    logic               miss7_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s7_reg[i]  <= s6_reg[i];
            dv7_reg[i] <= dv6_reg[i];
        end
        bq7_reg   <= bq6_reg;
        sum7_reg  <= 64'(sq6_reg[0]) + 64'(sq6_reg[1]) + 64'(sq6_reg[2]);
        r2_7_reg  <= r2_6_reg;
        miss7_reg <= miss6_reg;
    end

    // ------------------------------------------------------------------------
    // Stage 8 and the square root: the discriminant r^2 - dist^2 feeds a
    // digit-by-digit root, one result bit per stage.
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic                   miss;
        logic signed [36:0]     bq;
        logic [2:0][31:0]       s;
        logic [2:0][15:0]       dv;
    } side_t;

    side_t       sq_side_reg [SQRT_STEPS+1];
    logic [61:0] sq_x_reg    [SQRT_STEPS+1];
    logic [61:0] sq_res_reg  [SQRT_STEPS+1];
    logic [61:0] sq_x_next   [SQRT_STEPS+1];
    logic [61:0] sq_res_next [SQRT_STEPS+1];
    side_t       sq_side_next;

    always_comb
    begin
        sq_side_next.miss = miss7_reg || (sum7_reg > {2'b0, r2_7_reg});
        sq_side_next.bq   = bq7_reg;
        for (int i = 0; i < 3; i++)
        begin
            sq_side_next.s[i]  = s7_reg[i];
            sq_side_next.dv[i] = dv7_reg[i];
        end
    end

    assign sq_x_next[0]   = r2_7_reg - sum7_reg[61:0];
    assign sq_res_next[0] = '0;

    always_ff @(posedge clk)
    begin
        sq_side_reg[0] <= sq_side_next;
        sq_x_reg[0]    <= sq_x_next[0];
        sq_res_reg[0]  <= sq_res_next[0];
    end

    for (genvar k = 1; k <= SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [62:0] BIT = 63'(1) << (2 * (SQRT_STEPS - k));
        logic [62:0] trial;
        logic        take;

        assign trial = {1'b0, sq_res_reg[k-1]} + BIT;
        assign take  = {1'b0, sq_x_reg[k-1]} >= trial;
        assign sq_x_next[k]   = take ? (sq_x_reg[k-1] - trial[61:0]) : sq_x_reg[k-1];
        assign sq_res_next[k] = take ? ((sq_res_reg[k-1] >> 1) + BIT[61:0])
                                     : (sq_res_reg[k-1] >> 1);

        always_ff @(posedge clk)
        begin
            sq_side_reg[k] <= sq_side_reg[k-1];
            sq_x_reg[k]    <= sq_x_next[k];
            sq_res_reg[k]  <= sq_res_next[k];
        end
    end

    // ------------------------------------------------------------------------
    // Near root t = -b - sqrt(d); a negative t means no hit.
    // ------------------------------------------------------------------------
    side_t              t_side_reg;
    side_t              t_side_next;
    logic signed [37:0] t_reg;
    logic signed [37:0] t_val;

    assign t_val = -38'(sq_side_reg[SQRT_STEPS].bq)
                 - $signed({7'b0, sq_res_reg[SQRT_STEPS][30:0]});

    always_comb
    begin
        t_side_next      = sq_side_reg[SQRT_STEPS];
        t_side_next.miss = sq_side_reg[SQRT_STEPS].miss || t_val[37];
    end

    always_ff @(posedge clk)
    begin
        t_side_reg <= t_side_next;
        t_reg      <= t_val;
    end

    // t * dir
    side_t              tm_side_reg;
    logic signed [53:0] tm_reg [3];

    always_ff @(posedge clk)
    begin
        tm_side_reg <= t_side_reg;
        for (int i = 0; i < 3; i++)
        begin
            tm_reg[i] <= 54'(t_reg) * 54'($signed(t_side_reg.dv[i]));
        end
    end

    // Hit point p = start + round(t * dir).
    logic               p_miss_reg;
    logic signed [40:0] p_reg [3];
    logic signed [53:0] tm_rnd [3];
    logic signed [53:0] tm_shift [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tm_rnd[i]   = tm_reg[i] + 54'(DIR_HALF);
            tm_shift[i] = tm_rnd[i] >>> DIR_FRAC;
        end
    end

    always_ff @(posedge clk)
    begin
        p_miss_reg <= tm_side_reg.miss;
        for (int i = 0; i < 3; i++)
        begin
            p_reg[i] <= 41'($signed(tm_side_reg.s[i])) + tm_shift[i][40:0];
        end
    end

    // Saturate the point and take |p - center|, clamped to the radius.
    typedef struct packed {
        logic             miss;
        logic [2:0][31:0] ps;
        logic [2:0]       neg;
    } dside_t;

    dside_t             pc_side_reg;
    logic [30:0]        pc_mag_reg [3];
    dside_t             pc_side_next;
    logic signed [41:0] pc_dif [3];
    logic [41:0]        pc_abs [3];

    always_comb
    begin
        pc_side_next.miss = p_miss_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (p_reg[i] > 41'sh0_7FFF_FFFF)
            begin
                pc_side_next.ps[i] = 32'h7FFF_FFFF;
            end
            else if (p_reg[i] < -41'sh0_8000_0000)
            begin
                pc_side_next.ps[i] = 32'h8000_0000;
            end
            else
            begin
                pc_side_next.ps[i] = p_reg[i][31:0];
            end
            pc_dif[i]           = 42'(p_reg[i]) - 42'(center_reg[i]);
            pc_side_next.neg[i] = pc_dif[i][41];
            pc_abs[i]           = pc_dif[i][41] ? 42'(-pc_dif[i]) : 42'(pc_dif[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        pc_side_reg <= pc_side_next;
        for (int i = 0; i < 3; i++)
        begin
            pc_mag_reg[i] <= (pc_abs[i] > {11'b0, r_eff}) ? r_eff : pc_abs[i][30:0];
        end
    end

    // ------------------------------------------------------------------------
    // Normal = (|p - c| * 2^14 + r/2) / r, restoring division, one quotient
    // bit per stage on all three axes at once.
    // ------------------------------------------------------------------------
    dside_t      dv_side_reg [DIV_STEPS+1];
    logic [45:0] dv_rem_reg  [DIV_STEPS+1][3];
    logic [14:0] dv_q_reg    [DIV_STEPS+1][3];

    always_ff @(posedge clk)
    begin
        dv_side_reg[0] <= pc_side_reg;
        for (int i = 0; i < 3; i++)
        begin
            dv_rem_reg[0][i] <= {1'b0, pc_mag_reg[i], 14'b0} + 46'(r_eff >> 1);
            dv_q_reg[0][i]   <= '0;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_div
        localparam int SH = DIV_STEPS - k;
        logic [45:0] dsr;

        assign dsr = 46'(r_eff) << SH;

        for (genvar j = 0; j < 3; j++)
        begin : g_lane
            logic take;

            assign take = dv_rem_reg[k-1][j] >= dsr;

            always_ff @(posedge clk)
            begin
                dv_rem_reg[k][j] <= take ? (dv_rem_reg[k-1][j] - dsr) : dv_rem_reg[k-1][j];
                dv_q_reg[k][j]   <= dv_q_reg[k-1][j] | (take ? (15'(1) << SH) : 15'(0));
            end
        end

        always_ff @(posedge clk)
        begin
            dv_side_reg[k] <= dv_side_reg[k-1];
        end
    end

    // ------------------------------------------------------------------------
    // Output register: apply the normal signs; a miss gives all zeros.
    // ------------------------------------------------------------------------
    hit_t        result_reg;
    hit_t        result_next;
    dside_t      fin;
    logic [15:0] nrm [3];

    assign fin = dv_side_reg[DIV_STEPS];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nrm[i] = fin.neg[i] ? (16'd0 - {1'b0, dv_q_reg[DIV_STEPS][i]})
                                : {1'b0, dv_q_reg[DIV_STEPS][i]};
        end
        if (fin.miss)
        begin
            result_next = '0;
        end
        else
        begin
            result_next.hit      = 1'b1;
            result_next.point_x  = fin.ps[0];
            result_next.point_y  = fin.ps[1];
            result_next.point_z  = fin.ps[2];
            result_next.normal_x = nrm[0];
            result_next.normal_y = nrm[1];
            result_next.normal_z = nrm[2];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // Every request comes out, with done high, after the pipeline latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##RSI_LAT done)
        else $error("request did not produce a result after the pipeline latency");

    // A miss carries all-zero fields.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |-> (result.point_x == '0 && result.point_y == '0 &&
        result.point_z == '0 && result.normal_x == '0 && result.normal_y == '0 &&
        result.normal_z == '0))
        else $error("miss result with nonzero fields");

    // Normal components never leave the unit range.
    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.normal_x <= 16'sd16384 && result.normal_x >= -16'sd16384 &&
        result.normal_y <= 16'sd16384 && result.normal_y >= -16'sd16384 &&
        result.normal_z <= 16'sd16384 && result.normal_z >= -16'sd16384))
        else $error("normal component out of range");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the ray / sphere intersection pipeline.
// ============================================================================
// Rays are sent through the command port and every result is compared,
// field by field, with the output of a predictor that works in the bench's
// own integer arithmetic. The sphere is reprogrammed over the APB port only
// while no request is in flight. Directed rays cover hits from every axis,
// origins inside and spheres behind, saturation, zero radius and
// non-unit directions. Random rays follow, mostly aimed at the sphere.
// ============================================================================
module tb_top;
    import rsi_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    ray_t        ray;
    logic        done;
    hit_t        result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ray_sphere_intersect uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .ray     (ray),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The bench's own copy of the sphere registers.
    logic signed [31:0] sph_cx, sph_cy, sph_cz;
    logic [30:0]        sph_r;

    // Expected hit records, oldest first.
    hit_t expected_hits[$];

    int mismatches;
    int hits_seen;
    int results_seen;
    int rays_sent;
    int idle_pct;
    int stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Square root rounded down, bit by bit.
    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // A product with a Q2.14 direction brought back to Q16.16, half up.
    // The arithmetic shift of a signed longint is a floor shift.
    function automatic longint dir_scale(input longint v);
        return (v + DIR_HALF) >>> DIR_FRAC;
    endfunction

    // Works out the hit record for one ray against the current sphere.
    function automatic hit_t predict_hit(input ray_t q);
        longint          s[3], c[3], dv[3], dif[3];
        longint          bsum, bq, t, perp, p, pc;
        longint unsigned r, sum, mag, n, r2;
        logic            is_hit;
        hit_t            h;
        s[0] = q.start_x;  s[1] = q.start_y;  s[2] = q.start_z;
        dv[0] = q.dir_x;   dv[1] = q.dir_y;   dv[2] = q.dir_z;
        c[0] = sph_cx;     c[1] = sph_cy;     c[2] = sph_cz;
        r = (sph_r == 0) ? 64'd1 : 64'(sph_r);
        bsum = 0;
        sum = 0;
        t = 0;
        is_hit = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            dif[i] = s[i] - c[i];
            bsum += dv[i] * dif[i];
        end
        bq = dir_scale(bsum);
        // Distance from the centre to the ray, one axis at a time.
        for (int i = 0; i < 3; i++)
        begin
            perp = dif[i] - dir_scale(bq * dv[i]);
            mag = (perp < 0) ? longint'(-perp) : longint'(perp);
            if (mag > r)
                is_hit = 1'b0;
            else
                sum += mag * mag;
        end
        if (is_hit)
        begin
            r2 = r * r;
            if (sum > r2)
                is_hit = 1'b0;
            else
            begin
                t = -bq - longint'(floor_sqrt(r2 - sum));
                if (t < 0) is_hit = 1'b0;
            end
        end
        h = '0;
        if (!is_hit) return h;
        h.hit = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            logic signed [31:0] ps;
            logic [15:0]        nv;
            p = s[i] + dir_scale(t * dv[i]);
            if (p > 64'sd2147483647)       ps = 32'h7FFF_FFFF;
            else if (p < -64'sd2147483648) ps = 32'h8000_0000;
            else                           ps = p[31:0];
            pc = p - c[i];
            mag = (pc < 0) ? longint'(-pc) : longint'(pc);
            if (mag > r) mag = r;
            n = ((mag << DIR_FRAC) + (r >> 1)) / r;
            nv = (pc < 0) ? 16'(-n) : 16'(n);
            case (i)
                0: begin h.point_x = ps; h.normal_x = nv; end
                1: begin h.point_y = ps; h.normal_y = nv; end
                default: begin h.point_z = ps; h.normal_z = nv; end
            endcase
        end
        return h;
    endfunction

    // Writes one sphere register: a setup phase, an access phase, then an idle
    // phase so that back-to-back writes each get their own setup phase.
    task automatic write_sphere_reg(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CENTER_X: sph_cx = val;
            REG_CENTER_Y: sph_cy = val;
            REG_CENTER_Z: sph_cz = val;
            default:      sph_r  = val[30:0];
        endcase
        @(posedge clk);
    endtask

    // Stops sending and waits for the pipeline to drain.
    task automatic drain_pipeline();
        start <= 1'b0;
        while (expected_hits.size() != 0) @(posedge clk);
        repeat (RSI_LAT + 4) @(posedge clk);
    endtask

    task automatic set_sphere(input logic signed [31:0] cx, input logic signed [31:0] cy,
                              input logic signed [31:0] cz, input logic [30:0] r);
        drain_pipeline();
        write_sphere_reg(REG_CENTER_X, cx);
        write_sphere_reg(REG_CENTER_Y, cy);
        write_sphere_reg(REG_CENTER_Z, cz);
        write_sphere_reg(REG_RADIUS, {1'b0, r});
    endtask

    // Sends one request, with a random gap first when the sender idles.
    // start stays high afterwards so that requests can follow back to back.
    task automatic send_ray(input ray_t q);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        ray   <= q;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_hits = {expected_hits, predict_hit(q)};
        rays_sent++;
    endtask

    function automatic ray_t make_ray(input longint sx, input longint sy, input longint sz,
                                      input int dx, input int dy, input int dz);
        ray_t q;
        q.start_x = sx[31:0];
        q.start_y = sy[31:0];
        q.start_z = sz[31:0];
        q.dir_x = dx[15:0];
        q.dir_y = dy[15:0];
        q.dir_z = dz[15:0];
        return q;
    endfunction

    // A unit-ish direction from the start towards the target; the components need not be exactly unit.
    function automatic ray_t aim_ray(input longint sx, input longint sy, input longint sz,
                                     input longint tx, input longint ty, input longint tz);
        real vx, vy, vz, len;
        vx = real'(tx - sx);
        vy = real'(ty - sy);
        vz = real'(tz - sz);
        len = $sqrt(vx * vx + vy * vy + vz * vz);
        if (len == 0.0) return make_ray(sx, sy, sz, 16384, 0, 0);
        return make_ray(sx, sy, sz, int'(vx / len * 16384.0),
                        int'(vy / len * 16384.0), int'(vz / len * 16384.0));
    endfunction

    // Compares each strobed result with the oldest expectation.
    initial
    begin
        hit_t exp_h;
        mismatches   = 0;
        results_seen = 0;
        hits_seen    = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && done)
            begin
                results_seen++;
                if (expected_hits.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Result with no request pending: %h", result);
                end
                else
                begin
                    exp_h = expected_hits.pop_front();
                    if (exp_h.hit) hits_seen++;
                    if (result !== exp_h)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("Mismatch: expected hit=%0b p=(%0d,%0d,%0d) n=(%0d,%0d,%0d)",
                                     exp_h.hit, exp_h.point_x, exp_h.point_y, exp_h.point_z,
                                     exp_h.normal_x, exp_h.normal_y, exp_h.normal_z);
                            $display("          actual   hit=%0b p=(%0d,%0d,%0d) n=(%0d,%0d,%0d)",
                                     result.hit, result.point_x, result.point_y,
                                     result.point_z, result.normal_x, result.normal_y,
                                     result.normal_z);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither a request nor a result moves.
    initial
    begin
        stall_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((start && !busy) || done) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Unit sphere at the origin as left by reset, shot from each axis.
    task automatic test_reset_sphere();
        send_ray(make_ray(-5 * 65536, 0, 0, 16384, 0, 0));
        send_ray(make_ray(0, 5 * 65536, 0, 0, -16384, 0));
        send_ray(make_ray(0, 0, -5 * 65536, 0, 0, 16384));
        // Origin inside the sphere, and sphere behind the ray.
        send_ray(make_ray(0, 0, 0, 16384, 0, 0));
        send_ray(make_ray(5 * 65536, 0, 0, 16384, 0, 0));
        // A clean miss to one side and a grazing ray.
        send_ray(make_ray(-5 * 65536, 2 * 65536, 0, 16384, 0, 0));
        send_ray(make_ray(-5 * 65536, 65536, 0, 16384, 0, 0));
    endtask

    // Field extremes, non-unit directions, saturation and the zero radius.
    task automatic test_extremes();
        set_sphere(32'sh7FFF_0000, -32'sh7FFF_0000, 0, 31'h7FFF_FFFF);
        send_ray(make_ray(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647,
                          16384, 0, 0));
        send_ray(make_ray(64'sd2147483647, 64'sd2147483647, -64'sd2147483648,
                          -16384, -16384, -16384));
        send_ray(make_ray(0, 0, 0, 32767, -32768, 1));
        send_ray(make_ray(0, 0, 0, -32768, 32767, -1));
        send_ray(make_ray(0, 0, 0, 0, 0, 0));
        set_sphere(-32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh8000_0000, 31'd0);
        send_ray(make_ray(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
                          0, 0, 16384));
        send_ray(make_ray(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648 + 10,
                          0, 0, -16384));
        set_sphere(0, 0, 0, 31'd1);
        send_ray(make_ray(-10, 0, 0, 16384, 0, 0));
        send_ray(make_ray(0, -10, 0, 0, 16384, 0));
        set_sphere(100 * 65536, 0, 0, 31'h7FFF_FFFF);
        send_ray(make_ray(0, 0, 0, 16384, 0, 0));
        send_ray(make_ray(0, 0, 0, 11585, 11585, 0));
    endtask

    // Random rays: most aimed at a random sphere, some aimed away from it, the rest pure noise.
    task automatic test_random_rays(input int count, input int pct);
        longint cx, cy, cz, r;
        idle_pct = pct;
        cx = $signed($urandom_range(4000)) - 2000;
        cy = $signed($urandom_range(4000)) - 2000;
        cz = $signed($urandom_range(4000)) - 2000;
        r  = $urandom_range(200 * 65536, 1);
        set_sphere(32'(cx * 65536), 32'(cy * 65536), 32'(cz * 65536), 31'(r));
        for (int k = 0; k < count; k++)
        begin
            longint sx, sy, sz, ox, oy, oz;
            int sel;
            sel = $urandom_range(9);
            if (sel < 8)
            begin
                // A ray from a point around the sphere, towards a point near it or, when sel is 7, away from it.
                sx = cx * 65536 + $signed($urandom_range(2000 * 65536)) - 1000 * 65536;
                sy = cy * 65536 + $signed($urandom_range(2000 * 65536)) - 1000 * 65536;
                sz = cz * 65536 + $signed($urandom_range(2000 * 65536)) - 1000 * 65536;
                ox = cx * 65536 + ($signed($urandom_range(2 * r)) - r);
                oy = cy * 65536 + ($signed($urandom_range(2 * r)) - r);
                oz = cz * 65536 + ($signed($urandom_range(2 * r)) - r);
                if (sel == 7)
                    send_ray(aim_ray(sx, sy, sz, 2 * sx - ox, 2 * sy - oy, 2 * sz - oz));
                else
                    send_ray(aim_ray(sx, sy, sz, ox, oy, oz));
            end
            else
                send_ray(make_ray($signed($urandom()), $signed($urandom()),
                                  $signed($urandom()), $signed($urandom_range(65535)),
                                  $signed($urandom_range(65535)),
                                  $signed($urandom_range(65535))));
        end
        idle_pct = 0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        ray       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        idle_pct  = 0;
        rays_sent = 0;
        sph_cx    = 0;
        sph_cy    = 0;
        sph_cz    = 0;
        sph_r     = RADIUS_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_sphere();
        test_extremes();
        test_random_rays(300, 0);
        // The sender holds off here until every result has come back.
        drain_pipeline();
        test_random_rays(300, 85);
        test_random_rays(300, 37);
        test_random_rays(300, 0);

        drain_pipeline();
        repeat (6) @(posedge clk);
        $display("Sent %0d rays over several sphere settings; %0d results, %0d hits.",
                 rays_sent, results_seen, hits_seen);
        if (mismatches == 0 && expected_hits.size() == 0)
            $display("== PASS ==");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_hits.size());
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

### sim.f
design/rsi_pkg.sv
design/ray_sphere_intersect.sv
test/tb_top.sv
